FILE: rtl/mupsa_pkg.sv
`timescale 1ns / 1ps

package mupsa_pkg;

   localparam int ADDR_BITS  = 40;
   localparam int VALUE_BITS = 32;
   localparam int DIM_BITS   = 16;
   localparam int INDEX_BITS = 32;

   // plane sizes and their products wrap at 64 bits
   localparam int MUL_BITS   = 64;
   localparam int PLANE_BITS = (3 * DIM_BITS > MUL_BITS) ? MUL_BITS : 3 * DIM_BITS;
   // spatial counter plus its carry, unless it already wraps at 64 bits
   localparam int SPC_BITS   = (3 * DIM_BITS >= MUL_BITS) ? MUL_BITS : 3 * DIM_BITS + 1;
   localparam int CNT_BITS   = $clog2(DIM_BITS);
   localparam int PROD_BITS  = INDEX_BITS + DIM_BITS;

   localparam int CSR_INDEX_BITS = 3;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_CHANNELS_LAST = 3'd0,
      REG_NUM_CHANNELS  = 3'd1,
      REG_IN_DEPTH      = 3'd2,
      REG_IN_HEIGHT     = 3'd3,
      REG_IN_WIDTH      = 3'd4,
      REG_OUT_DEPTH     = 3'd5,
      REG_OUT_HEIGHT    = 3'd6,
      REG_OUT_WIDTH     = 3'd7
   } csr_reg_type;

   typedef enum logic [1:0] {
      GEOM_IDLE,
      GEOM_LOAD,
      GEOM_RUN
   } geom_state_type;

   typedef enum logic [2:0] {
      STEP_OPLANE_HW,
      STEP_OPLANE,
      STEP_IPLANE_HW,
      STEP_IPLANE,
      STEP_CPLANE,
      STEP_CHOFF
   } geom_step_type;

   typedef struct packed {
      logic [VALUE_BITS-1:0] pooled_value;
      logic [INDEX_BITS-1:0] max_index;
      logic                  last_element;
   } req_type;

   typedef struct packed {
      logic [ADDR_BITS-1:0]  write_address;
      logic [VALUE_BITS-1:0] write_value;
      logic                  write_enable;
      logic                  index_out_of_range;
   } rsp_type;

   // layout and plane sizes seen by the address path
   typedef struct packed {
      logic                  channels_last;
      logic [DIM_BITS-1:0]   chans;
      logic [PLANE_BITS-1:0] oplane;
      logic [PLANE_BITS-1:0] iplane;
      logic [ADDR_BITS-1:0]  cplane;
      logic                  busy;
   } geom_type;

   // channel offset reload after a geometry change
   typedef struct packed {
      logic                 valid;
      logic [ADDR_BITS-1:0] value;
   } reload_type;

   function automatic logic [DIM_BITS-1:0] eff_dim(input logic [DIM_BITS-1:0] v);
      return (v == '0) ? DIM_BITS'(1) : v;
   endfunction

endpackage

FILE: rtl/mupsa_geom.sv
`timescale 1ns / 1ps

module mupsa_geom (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic [mupsa_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [mupsa_pkg::DIM_BITS-1:0]           csr_data,
   input  logic [mupsa_pkg::DIM_BITS-1:0]           channel_count,
   output mupsa_pkg::geom_type                      geom,
   output mupsa_pkg::reload_type                    reload
);

   localparam int D = mupsa_pkg::DIM_BITS;
   localparam int M = mupsa_pkg::MUL_BITS;

   mupsa_pkg::geom_state_type state_ff, state_in;
   mupsa_pkg::geom_step_type  step_ff, step_in;

   logic         cl_ff, cl_in;
   logic [D-1:0] chans_ff, chans_in;
   logic [D-1:0] id_ff, id_in, ih_ff, ih_in, iw_ff, iw_in;
   logic [D-1:0] od_ff, od_in, oh_ff, oh_in, ow_ff, ow_in;

   logic [mupsa_pkg::PLANE_BITS-1:0] oplane_ff, oplane_in;
   logic [mupsa_pkg::PLANE_BITS-1:0] iplane_ff, iplane_in;
   logic [mupsa_pkg::ADDR_BITS-1:0]  cplane_ff, cplane_in;

   // shift-add multiplier, one multiplier bit per cycle
   logic [M-1:0]                   a_ff, a_in;
   logic [D-1:0]                   b_ff, b_in;
   logic [M-1:0]                   acc_ff, acc_in;
   logic [M-1:0]                   tmp_ff, tmp_in;
   logic [mupsa_pkg::CNT_BITS-1:0] cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= mupsa_pkg::GEOM_IDLE;
         step_ff   <= mupsa_pkg::STEP_OPLANE_HW;
         cl_ff     <= 1'b0;
         chans_ff  <= D'(1);
         id_ff     <= D'(1);
         ih_ff     <= D'(1);
         iw_ff     <= D'(1);
         od_ff     <= D'(1);
         oh_ff     <= D'(1);
         ow_ff     <= D'(1);
         oplane_ff <= mupsa_pkg::PLANE_BITS'(1);
         iplane_ff <= mupsa_pkg::PLANE_BITS'(1);
         cplane_ff <= mupsa_pkg::ADDR_BITS'(1);
      end else begin
         state_ff  <= state_in;
         step_ff   <= step_in;
         cl_ff     <= cl_in;
         chans_ff  <= chans_in;
         id_ff     <= id_in;
         ih_ff     <= ih_in;
         iw_ff     <= iw_in;
         od_ff     <= od_in;
         oh_ff     <= oh_in;
         ow_ff     <= ow_in;
         oplane_ff <= oplane_in;
         iplane_ff <= iplane_in;
         cplane_ff <= cplane_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
      tmp_ff <= tmp_in;
      cnt_ff <= cnt_in;
   end

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      cl_in     = cl_ff;
      chans_in  = chans_ff;
      id_in     = id_ff;
      ih_in     = ih_ff;
      iw_in     = iw_ff;
      od_in     = od_ff;
      oh_in     = oh_ff;
      ow_in     = ow_ff;
      oplane_in = oplane_ff;
      iplane_in = iplane_ff;
      cplane_in = cplane_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      acc_in    = acc_ff;
      tmp_in    = tmp_ff;
      cnt_in    = cnt_ff;
      reload    = '0;
      csr_ready = (state_ff == mupsa_pkg::GEOM_IDLE);

      unique case (state_ff)
         mupsa_pkg::GEOM_IDLE: begin
            if (csr_valid) begin
               unique case (mupsa_pkg::csr_reg_type'(csr_index))
                  mupsa_pkg::REG_CHANNELS_LAST: cl_in    = csr_data[0];
                  mupsa_pkg::REG_NUM_CHANNELS:  chans_in = mupsa_pkg::eff_dim(csr_data);
                  mupsa_pkg::REG_IN_DEPTH:      id_in    = mupsa_pkg::eff_dim(csr_data);
                  mupsa_pkg::REG_IN_HEIGHT:     ih_in    = mupsa_pkg::eff_dim(csr_data);
                  mupsa_pkg::REG_IN_WIDTH:      iw_in    = mupsa_pkg::eff_dim(csr_data);
                  mupsa_pkg::REG_OUT_DEPTH:     od_in    = mupsa_pkg::eff_dim(csr_data);
                  mupsa_pkg::REG_OUT_HEIGHT:    oh_in    = mupsa_pkg::eff_dim(csr_data);
                  mupsa_pkg::REG_OUT_WIDTH:     ow_in    = mupsa_pkg::eff_dim(csr_data);
               endcase
               state_in = mupsa_pkg::GEOM_LOAD;
               step_in  = mupsa_pkg::STEP_OPLANE_HW;
            end
         end
         mupsa_pkg::GEOM_LOAD: begin
            acc_in   = '0;
            cnt_in   = '0;
            state_in = mupsa_pkg::GEOM_RUN;
            unique case (step_ff)
               mupsa_pkg::STEP_OPLANE_HW: begin
                  a_in = M'(oh_ff);
                  b_in = ow_ff;
               end
               mupsa_pkg::STEP_OPLANE: begin
                  a_in = tmp_ff;
                  b_in = od_ff;
               end
               mupsa_pkg::STEP_IPLANE_HW: begin
                  a_in = M'(ih_ff);
                  b_in = iw_ff;
               end
               mupsa_pkg::STEP_IPLANE: begin
                  a_in = tmp_ff;
                  b_in = id_ff;
               end
               mupsa_pkg::STEP_CPLANE: begin
                  a_in = M'(oplane_ff);
                  b_in = chans_ff;
               end
               mupsa_pkg::STEP_CHOFF: begin
                  a_in = M'(oplane_ff);
                  b_in = channel_count;
               end
               default: begin
                  a_in     = '0;
                  b_in     = '0;
                  state_in = mupsa_pkg::GEOM_IDLE;
               end
            endcase
         end
         mupsa_pkg::GEOM_RUN: begin
            acc_in = acc_ff + (b_ff[0] ? a_ff : '0);
            a_in   = a_ff << 1;
            b_in   = b_ff >> 1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == mupsa_pkg::CNT_BITS'(D - 1)) begin
               state_in = mupsa_pkg::GEOM_LOAD;
               unique case (step_ff)
                  mupsa_pkg::STEP_OPLANE_HW: begin
                     tmp_in  = acc_in;
                     step_in = mupsa_pkg::STEP_OPLANE;
                  end
                  mupsa_pkg::STEP_OPLANE: begin
                     oplane_in = mupsa_pkg::PLANE_BITS'(acc_in);
                     step_in   = mupsa_pkg::STEP_IPLANE_HW;
                  end
                  mupsa_pkg::STEP_IPLANE_HW: begin
                     tmp_in  = acc_in;
                     step_in = mupsa_pkg::STEP_IPLANE;
                  end
                  mupsa_pkg::STEP_IPLANE: begin
                     iplane_in = mupsa_pkg::PLANE_BITS'(acc_in);
                     step_in   = mupsa_pkg::STEP_CPLANE;
                  end
                  mupsa_pkg::STEP_CPLANE: begin
                     cplane_in = mupsa_pkg::ADDR_BITS'(acc_in);
                     step_in   = mupsa_pkg::STEP_CHOFF;
                  end
                  mupsa_pkg::STEP_CHOFF: begin
                     reload.valid = 1'b1;
                     reload.value = mupsa_pkg::ADDR_BITS'(acc_in);
                     state_in     = mupsa_pkg::GEOM_IDLE;
                  end
                  default: state_in = mupsa_pkg::GEOM_IDLE;
               endcase
            end
         end
         default: state_in = mupsa_pkg::GEOM_IDLE;
      endcase
   end

   always_comb begin
      geom.channels_last = cl_ff;
      geom.chans         = chans_ff;
      geom.oplane        = oplane_ff;
      geom.iplane        = iplane_ff;
      geom.cplane        = cplane_ff;
      geom.busy          = (state_ff != mupsa_pkg::GEOM_IDLE);
   end

endmodule

FILE: rtl/mupsa_addr.sv
`timescale 1ns / 1ps

module mupsa_addr (
   input  logic                          clock,
   input  logic                          reset,
   input  mupsa_pkg::geom_type           geom,
   input  mupsa_pkg::reload_type         reload,
   output logic [mupsa_pkg::DIM_BITS-1:0] channel_count,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  mupsa_pkg::req_type            req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output mupsa_pkg::rsp_type            rsp_data
);

   localparam int D   = mupsa_pkg::DIM_BITS;
   localparam int A   = mupsa_pkg::ADDR_BITS;
   localparam int P   = mupsa_pkg::PLANE_BITS;
   localparam int SPC = mupsa_pkg::SPC_BITS;

   // running position
   logic [D-1:0] ch_ff, ch_in;
   logic [P-1:0] sp_ff, sp_in;
   logic [A-1:0] sample_base_ff, sample_base_in;
   logic [A-1:0] choff_ff, choff_in;   // ch_ff * oplane

   // input stage
   logic                             s1_valid_ff, s1_valid_in;
   logic [A-1:0]                     s1_base_ff;
   logic [mupsa_pkg::INDEX_BITS-1:0] s1_idx_ff;
   logic [mupsa_pkg::VALUE_BITS-1:0] s1_value_ff;
   logic                             s1_oor_ff;
   logic                             s1_cl_ff;

   // result stage
   logic               rsp_valid_ff, rsp_valid_in;
   mupsa_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic                            out_free, s1_move, accept;
   logic [D:0]                      ch_inc;
   logic                            ch_wrap;
   logic [SPC-1:0]                  sp_inc;
   logic                            sp_wrap;
   logic [A-1:0]                    base_step;
   logic [A-1:0]                    s1_base_in;
   logic                            oor;
   logic [mupsa_pkg::PROD_BITS-1:0] prod, offset;
   logic [A-1:0]                    addr;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_move   = s1_valid_ff && out_free;
   assign req_stall = geom.busy || (s1_valid_ff && !out_free);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      ch_inc    = (D + 1)'(ch_ff) + 1'b1;
      ch_wrap   = ch_inc >= (D + 1)'(geom.chans);
      sp_inc    = SPC'(sp_ff) + 1'b1;
      sp_wrap   = sp_inc >= SPC'(geom.iplane);
      base_step = sample_base_ff + geom.cplane;

      s1_base_in = sample_base_ff + (geom.channels_last ? A'(ch_ff) : choff_ff);
      oor = mupsa_pkg::MUL_BITS'(req_data.max_index) >= mupsa_pkg::MUL_BITS'(geom.oplane);

      ch_in          = ch_ff;
      sp_in          = sp_ff;
      sample_base_in = sample_base_ff;
      choff_in       = choff_ff;

      if (reload.valid) begin
         choff_in = reload.value;
      end else if (accept) begin
         if (req_data.last_element) begin
            ch_in          = '0;
            sp_in          = '0;
            sample_base_in = '0;
            choff_in       = '0;
         end else if (geom.channels_last) begin
            if (ch_wrap) begin
               ch_in    = '0;
               choff_in = '0;
               if (sp_wrap) begin
                  sp_in          = '0;
                  sample_base_in = base_step;
               end else begin
                  sp_in = P'(sp_inc);
               end
            end else begin
               ch_in    = D'(ch_inc);
               choff_in = choff_ff + A'(geom.oplane);
            end
         end else begin
            if (sp_wrap) begin
               sp_in = '0;
               if (ch_wrap) begin
                  ch_in          = '0;
                  choff_in       = '0;
                  sample_base_in = base_step;
               end else begin
                  ch_in    = D'(ch_inc);
                  choff_in = choff_ff + A'(geom.oplane);
               end
            end else begin
               sp_in = P'(sp_inc);
            end
         end
      end
   end

   always_comb begin
      prod   = s1_idx_ff * geom.chans;
      offset = s1_cl_ff ? prod : mupsa_pkg::PROD_BITS'(s1_idx_ff);
      addr   = s1_base_ff + A'(offset);

      rsp_data_in.write_address      = s1_oor_ff ? '0 : addr;
      rsp_data_in.write_value        = s1_value_ff;
      rsp_data_in.write_enable       = !s1_oor_ff;
      rsp_data_in.index_out_of_range = s1_oor_ff;

      s1_valid_in  = accept ? 1'b1 : (s1_move ? 1'b0 : s1_valid_ff);
      rsp_valid_in = s1_move ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ch_ff          <= '0;
         sp_ff          <= '0;
         sample_base_ff <= '0;
         choff_ff       <= '0;
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         ch_ff          <= ch_in;
         sp_ff          <= sp_in;
         sample_base_ff <= sample_base_in;
         choff_ff       <= choff_in;
         s1_valid_ff    <= s1_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_base_ff  <= s1_base_in;
         s1_idx_ff   <= req_data.max_index;
         s1_value_ff <= req_data.pooled_value;
         s1_oor_ff   <= oor;
         s1_cl_ff    <= geom.channels_last;
      end
      if (s1_move) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign channel_count = ch_ff;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_data      = rsp_data_ff;

endmodule

FILE: rtl/max_unpool_scatter_address.sv
`timescale 1ns / 1ps

// Max-unpooling scatter address generator. Pooled elements stream in on req_
// in storage order, one word per cycle unless req_stall is high; each yields
// one scatter write on rsp_ through the input stage and result stage, with
// the output offset, the value, a write enable and an out-of-range flag. The
// channel, spatial and sample counters run in the input stage and return to
// zero after a word with last_element set. Each configuration write starts a
// recompute of the plane sizes and the current channel offset on a shared
// shift-add multiplier, one multiplier bit per cycle; csr_ready is low and
// req_stall high until it ends, else req_stall only follows rsp_ back-pressure.
module max_unpool_scatter_address (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  mupsa_pkg::req_type                   req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output mupsa_pkg::rsp_type                   rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [mupsa_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [mupsa_pkg::DIM_BITS-1:0]       csr_data
);

   mupsa_pkg::geom_type               geom;
   mupsa_pkg::reload_type             reload;
   logic [mupsa_pkg::DIM_BITS-1:0]    channel_count;

   mupsa_geom u_geom (
      .clock         (clock),
      .reset         (reset),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .channel_count (channel_count),
      .geom          (geom),
      .reload        (reload)
   );

   mupsa_addr u_addr (
      .clock         (clock),
      .reset         (reset),
      .geom          (geom),
      .reload        (reload),
      .channel_count (channel_count),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data)
   );

endmodule
